@@ rtl/core/assert_macros.svh @@
// Assertion macros for the LRU key-value cache.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under reset gating
`define LKV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lkv assertion failed");

// check on every edge, reset included
`define LKV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lkv assertion failed");

`endif

@@ rtl/core/lkv_pkg.sv @@
// Shared constants and the cell control type of the LRU key-value cache.
// No dependencies.
package lkv_pkg;

  localparam int DATA_W   = 32;
  localparam int KEY_IN_W = 32;
  localparam int CAP_W    = 7;
  localparam int CAP_RST  = 64;

  typedef struct packed {
    logic cmp;
    logic upd;
    logic shift;
    logic keep;
  } cell_ctrl_t;

endpackage

@@ rtl/core/lkv_intf.sv @@
// Request, response and configuration channels of the LRU key-value cache.
// Depends on lkv_pkg.
interface lkv_req_if;
  import lkv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [KEY_IN_W-1:0] key;
  logic signed [DATA_W-1:0]   value;
  modport source (output valid, mode, key, value, input ready);
  modport sink (input valid, mode, key, value, output ready);
endinterface

interface lkv_rsp_if;
  import lkv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink (input valid, hit, read_value, output ready);
endinterface

interface lkv_cfg_if;
  import lkv_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/lkv_cell.sv @@
// One position of the recency-ordered entry row: key, value, valid, match.
// Depends on lkv_pkg.
module lkv_cell #(
  parameter int KEY_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lkv_pkg::cell_ctrl_t        ctrl,
  input  logic [KEY_BITS-1:0]        left_key,
  input  logic [lkv_pkg::DATA_W-1:0] left_value,
  input  logic [KEY_BITS-1:0]        req_key,
  output logic [KEY_BITS-1:0]        key,
  output logic [lkv_pkg::DATA_W-1:0] value,
  output logic                       match
);
  import lkv_pkg::*;

  logic valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        match <= valid && (key == req_key);
      end
      if (ctrl.upd) begin
        valid <= ctrl.keep;
      end
    end
  end

  // advance neighbor entry one place toward the tail
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key   <= left_key;
      value <= left_value;
    end
  end

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// Channel  Role    Payload                     Handshake
// req      sink    mode, key, value            valid/ready
// rsp      source  hit, read_value             valid/ready
// cfg      sink    data (capacity)             valid/ready, ready always high
// A request goes through accept, compare in every cell and update of the row, in that order.
// The row shift and the one-hot readout of the cell matches take place in the update.
// A get stays in update while the result register is full and not taken.
// Reset clears the cell valid bits and occupancy and
// restores the capacity to its reset value.
// Top level of the LRU key-value cache; depends on lkv_pkg, lkv_intf, lkv_cell
// and assert_macros.svh.
module lru_key_value_cache #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  lkv_req_if.sink  req,
  lkv_rsp_if.source rsp,
  lkv_cfg_if.sink  cfg
);
  import lkv_pkg::*;

  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW      = (CW > CAP_W) ? CW : CAP_W;
  localparam int LIM_RST = (CAP_RST > ENTRIES) ? ENTRIES : CAP_RST;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t              state;
  logic                req_mode;
  logic [KEY_BITS-1:0] req_key;
  logic [DATA_W-1:0]   req_value;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       count_dec;
  logic [CW-1:0]       count_inc;
  logic [CW-1:0]       lim;
  logic [LW-1:0]       cap_ext;
  logic                rsp_valid;
  logic                rsp_hit;
  logic [DATA_W-1:0]   rsp_value;

  logic [KEY_BITS-1:0] key_arr [ENTRIES];
  logic [DATA_W-1:0]   val_arr [ENTRIES];
  logic [ENTRIES-1:0]  match_vec;
  cell_ctrl_t          ctrl [ENTRIES];

  logic                hit;
  logic [IW-1:0]       hit_pos;
  logic [DATA_W-1:0]   hit_val;
  logic [DATA_W-1:0]   front_value;
  logic                out_free;
  logic                advance;

  assign req.ready      = (state == ST_IDLE);
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;

  assign hit         = |match_vec;
  assign out_free    = !rsp_valid || rsp.ready;
  assign advance     = (state == ST_UPD) && (req_mode || out_free);
  assign front_value = req_mode ? req_value : hit_val;
  assign cap_ext     = LW'(cfg.data);

  always_comb begin
    hit_val = '0;
    hit_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_val = hit_val | val_arr[i];
        hit_pos = hit_pos | IW'(i);
      end
    end
  end

  always_comb begin
    count_dec  = count - CW'(1);
    count_inc  = count + CW'(1);
    count_next = count;
    if (req_mode) begin
      if (hit) begin
        count_next = (count_dec >= lim) ? count_dec : count;
      end else begin
        count_next = (count >= lim) ? count : count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      lim       <= CW'(LIM_RST);
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (advance) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (advance) begin
        count <= count_next;
      end
      if (cfg.valid) begin
        if (cap_ext == '0) begin
          lim <= CW'(1);
        end else if (cap_ext > LW'(ENTRIES)) begin
          lim <= CW'(ENTRIES);
        end else begin
          lim <= CW'(cap_ext);
        end
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (advance && !req_mode) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  // capture request payload and the result
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_mode  <= req.mode;
      req_key   <= KEY_BITS'(req.key);
      req_value <= req.value;
    end
    if (advance && !req_mode) begin
      rsp_hit   <= hit;
      rsp_value <= hit ? hit_val : '1;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_row
    localparam logic [IW-1:0] POS = IW'(i);

    assign ctrl[i].cmp   = (state == ST_LOOK);
    assign ctrl[i].upd   = advance;
    assign ctrl[i].shift = advance && ((req_mode && !hit) || (hit && (POS <= hit_pos)));
    assign ctrl[i].keep  = (CW'(i) < count_next);

    if (i == 0) begin : g_head
      lkv_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl[i]),
        .left_key   (req_key),
        .left_value (front_value),
        .req_key    (req_key),
        .key        (key_arr[i]),
        .value      (val_arr[i]),
        .match      (match_vec[i])
      );
    end else begin : g_body
      lkv_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl[i]),
        .left_key   (key_arr[i-1]),
        .left_value (val_arr[i-1]),
        .req_key    (req_key),
        .key        (key_arr[i]),
        .value      (val_arr[i]),
        .match      (match_vec[i])
      );
    end
  end

`include "assert_macros.svh"

  `LKV_ASSERT(a_unique_match, clk, rst, (state == ST_UPD) |-> $onehot0(match_vec))
  `LKV_ASSERT(a_count_bound, clk, rst, (count <= CW'(ENTRIES)) && (lim != '0))
  `LKV_ASSERT(a_accept_look, clk, rst, (req.valid && req.ready) |=> (state == ST_LOOK))
  `LKV_ASSERT_ALWAYS(a_miss_value, clk, (rsp_valid && !rsp_hit) |-> (rsp_value == '1))

endmodule

@@ dv/tb_lru_key_value_cache.sv @@
// Self-checking testbench for the LRU key-value cache: directed lookups and
// inserts, then random traffic over several capacity settings.
// Depends on lkv_pkg, the lkv_intf channels and the lru_key_value_cache RTL.
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  localparam int ENTRIES = 64;
  localparam int KEY_BITS = 32;
  localparam bit MODE_GET = 1'b0;
  localparam bit MODE_SET = 1'b1;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int POOL_SIZE = 128;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } lookup_result_t;

  class lru_scoreboard;
    logic [KEY_BITS-1:0] keys[ENTRIES];
    logic [DATA_W-1:0]   vals[ENTRIES];
    bit                  used[ENTRIES];
    int unsigned         rank[ENTRIES];
    int unsigned         occupied;
    int unsigned         capacity;
    lookup_result_t      expected_lookups[$];
    int                  fails;
    int                  gets;
    int                  sets;
    int                  hits;
    int                  evictions;

    function void reset_state();
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] = 1'b0;
        rank[i] = 0;
      end
      occupied = 0;
      capacity = CAP_RST;
      expected_lookups.delete();
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int unsigned fill_limit();
      int unsigned c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    function int find_slot(logic [KEY_BITS-1:0] k);
      for (int i = 0; i < ENTRIES; i++)
        if (used[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function void drop_slot(int s);
      int unsigned r;
      r = rank[s];
      used[s] = 1'b0;
      rank[s] = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (used[i] && rank[i] > r) rank[i]--;
      if (occupied > 0) occupied--;
    endfunction

    function void touch_slot(int s);
      int unsigned r;
      r = rank[s];
      for (int i = 0; i < ENTRIES; i++)
        if (used[i] && rank[i] < r) rank[i]++;
      rank[s] = 0;
    endfunction

    function void note_request(bit mode, logic [KEY_BITS-1:0] k, logic [DATA_W-1:0] v);
      int             s;
      int unsigned    oldest;
      lookup_result_t res;
      s = find_slot(k);
      if (mode == MODE_GET) begin
        gets++;
        if (s >= 0) begin
          touch_slot(s);
          hits++;
          res.hit = 1'b1;
          res.read_value = vals[s];
        end else begin
          res.hit = 1'b0;
          res.read_value = '1;
        end
        expected_lookups.push_back(res);
        return;
      end
      sets++;
      if (s >= 0) drop_slot(s);
      if (occupied >= fill_limit()) begin
        oldest = occupied - 1;
        for (int i = 0; i < ENTRIES; i++)
          if (used[i] && rank[i] == oldest) begin
            drop_slot(i);
            evictions++;
            break;
          end
      end
      s = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (!used[i]) begin
          s = i;
          break;
        end
      if (s < 0) return;
      for (int i = 0; i < ENTRIES; i++)
        if (used[i]) rank[i]++;
      keys[s] = k;
      vals[s] = v;
      used[s] = 1'b1;
      rank[s] = 0;
      occupied++;
    endfunction

    function void check_response(logic hit, logic [DATA_W-1:0] rv);
      lookup_result_t exp;
      if (expected_lookups.size() == 0) begin
        fails++;
        if (fails <= MAX_SHOWN)
          $display("unexpected response: hit=%0b read_value=%08h", hit, rv);
        return;
      end
      exp = expected_lookups.pop_front();
      if (hit !== exp.hit || rv !== exp.read_value) begin
        fails++;
        if (fails <= MAX_SHOWN)
          $display("response mismatch: expected hit=%0b read_value=%08h, got hit=%0b read_value=%08h",
                   exp.hit, exp.read_value, hit, rv);
      end
    endfunction

    function int pending_count();
      return expected_lookups.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  lkv_req_if req();
  lkv_rsp_if rsp();
  lkv_cfg_if cfg();

  lru_key_value_cache #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  lru_scoreboard shadow = new();
  logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
  bit steady_phase = 1'b0;
  bit hold_req = 1'b0;
  int cycle_count = 0;
  int cap_writes = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles with %0d responses outstanding",
               CYCLE_LIMIT, shadow.pending_count());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin : response_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        shadow.check_response(rsp.hit, rsp.read_value);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  task automatic send_request(bit mode, logic [KEY_BITS-1:0] k, logic [DATA_W-1:0] v);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= mode;
    req.key <= k;
    req.value <= v;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    shadow.note_request(mode, k, v);
  endtask

  task automatic drain_lookups();
    req.valid <= 1'b0;
    while (shadow.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    cfg.valid <= 1'b1;
    cfg.data <= c;
    @(posedge clk);
    while (cfg.ready !== 1'b1) @(posedge clk);
    cfg.valid <= 1'b0;
    shadow.set_capacity(c);
    cap_writes++;
  endtask

  task automatic random_request(int pool_n, int set_pct);
    bit                  mode;
    logic [KEY_BITS-1:0] k;
    logic [DATA_W-1:0]   v;
    int                  r;
    mode = ($urandom_range(0, 99) < set_pct) ? MODE_SET : MODE_GET;
    if ($urandom_range(0, 9) == 0) k = $urandom;
    else k = key_pool[$urandom_range(0, pool_n - 1)];
    r = $urandom_range(0, 19);
    case (r)
      0: v = '0;
      1: v = '1;
      2: v = 32'h8000_0000;
      3: v = 32'h7FFF_FFFF;
      default: v = $urandom;
    endcase
    send_request(mode, k, v);
  endtask

  task automatic run_requests(int n, int pool_n, int set_pct);
    for (int i = 0; i < n; i++) random_request(pool_n, set_pct);
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] caps[8];
    int               eff;
    int               pool_n;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.mode <= MODE_GET;
    req.key <= '0;
    req.value <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    shadow.reset_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // empty cache, extreme keys and values, update in place
    send_request(MODE_GET, 32'h0000_0000, 32'h0);
    send_request(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_SET, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_GET, 32'h7FFF_FFFF, 32'h0);
    send_request(MODE_GET, 32'h8000_0000, 32'h0);
    send_request(MODE_GET, 32'h0000_0000, 32'h0);
    send_request(MODE_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(MODE_SET, 32'h0000_0000, 32'h0000_3039);
    send_request(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(MODE_GET, 32'h0000_0001, 32'h0);
    drain_lookups();

    // zero capacity behaves as one entry
    write_capacity(7'd0);
    send_request(MODE_SET, 32'h0000_0005, 32'hA5A5_A5A5);
    send_request(MODE_SET, 32'h0000_0006, 32'h5A5A_5A5A);
    send_request(MODE_GET, 32'h0000_0005, 32'h0);
    send_request(MODE_GET, 32'h0000_0006, 32'h0);
    drain_lookups();

    // recency order decides the victim
    write_capacity(7'd2);
    send_request(MODE_SET, 32'h0000_0001, 32'h1111_1111);
    send_request(MODE_SET, 32'h0000_0002, 32'h2222_2222);
    send_request(MODE_GET, 32'h0000_0001, 32'h0);
    send_request(MODE_SET, 32'h0000_0003, 32'h3333_3333);
    send_request(MODE_GET, 32'h0000_0002, 32'h0);
    send_request(MODE_GET, 32'h0000_0001, 32'h0);
    send_request(MODE_GET, 32'h0000_0003, 32'h0);
    drain_lookups();

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    caps[0] = 7'd64;
    caps[1] = 7'd3;
    caps[2] = 7'd127;
    caps[3] = 7'd1;
    caps[4] = 7'd65;
    caps[5] = 7'($urandom_range(2, 63));
    caps[6] = 7'd0;
    caps[7] = 7'($urandom_range(0, 127));

    for (int p = 0; p < 8; p++) begin
      drain_lookups();
      write_capacity(caps[p]);
      steady_phase = (p % 3 == 2);
      eff = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
      pool_n = eff + eff / 2 + 2;
      if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;
      if (p == 0) begin
        run_requests(100, pool_n, 60);
        // stall the response side and keep lookups coming
        hold_req = 1'b1;
        run_requests(40, pool_n, 0);
        run_requests(70, pool_n, 45);
      end else if (p == 4) begin
        run_requests(100, pool_n, 45);
        drain_lookups();
        run_requests(110, pool_n, 45);
      end else begin
        run_requests(210, pool_n, 45);
      end
    end
    steady_phase = 1'b0;
    drain_lookups();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d gets (%0d hits) and %0d sets with %0d evictions",
             shadow.gets, shadow.hits, shadow.sets, shadow.evictions);
    $display("across %0d capacity writes, from zero up to the 7-bit maximum", cap_writes);
    if (shadow.fails == 0 && shadow.pending_count() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
